// ----- rtl/fwhw_pkg.sv -----
// Package: types, constants and table functions of the full-width to half-width folder.
package fwhw_pkg;

    localparam int unsigned TABLE_ENTRIES = 95;
    localparam int unsigned IDX_W         = 7;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_UTF8 = 2'd1;
    localparam logic [1:0] MODE_EUC  = 2'd2;

    localparam logic [7:0] ASCII_BASE = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       string_end;
    } t_out_item;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_match;

    // EUC-JP forms of ASCII 0x20 .. 0x7E, in table order.
    localparam logic [15:0] EUC_FORMS [TABLE_ENTRIES] = '{
        16'hA1A1, 16'hA1AA, 16'hA1C9, 16'hA1F4, 16'hA1F0, 16'hA1F3, 16'hA1F5, 16'hA1C7,
        16'hA1CA, 16'hA1CB, 16'hA1F6, 16'hA1DC, 16'hA1A4, 16'hA1DD, 16'hA1A5, 16'hA1BF,
        16'hA3B0, 16'hA3B1, 16'hA3B2, 16'hA3B3, 16'hA3B4, 16'hA3B5, 16'hA3B6, 16'hA3B7,
        16'hA3B8, 16'hA3B9, 16'hA1A7, 16'hA1A8, 16'hA1E3, 16'hA1E1, 16'hA1E4, 16'hA1A9,
        16'hA1F7, 16'hA3C1, 16'hA3C2, 16'hA3C3, 16'hA3C4, 16'hA3C5, 16'hA3C6, 16'hA3C7,
        16'hA3C8, 16'hA3C9, 16'hA3CA, 16'hA3CB, 16'hA3CC, 16'hA3CD, 16'hA3CE, 16'hA3CF,
        16'hA3D0, 16'hA3D1, 16'hA3D2, 16'hA3D3, 16'hA3D4, 16'hA3D5, 16'hA3D6, 16'hA3D7,
        16'hA3D8, 16'hA3D9, 16'hA3DA, 16'hA1CE, 16'hA1EF, 16'hA1CF, 16'hA1B0, 16'hA1B2,
        16'hA1C6, 16'hA3E1, 16'hA3E2, 16'hA3E3, 16'hA3E4, 16'hA3E5, 16'hA3E6, 16'hA3E7,
        16'hA3E8, 16'hA3E9, 16'hA3EA, 16'hA3EB, 16'hA3EC, 16'hA3ED, 16'hA3EE, 16'hA3EF,
        16'hA3F0, 16'hA3F1, 16'hA3F2, 16'hA3F3, 16'hA3F4, 16'hA3F5, 16'hA3F6, 16'hA3F7,
        16'hA3F8, 16'hA3F9, 16'hA3FA, 16'hA1D0, 16'hA1C3, 16'hA1D1, 16'hA1C1
    };

    // Three-byte UTF-8 full-width form of table entry idx (ASCII 0x20 + idx).
    function automatic logic [23:0] utf8_form(input logic [IDX_W-1:0] idx);
        logic [7:0] c;
        logic [7:0] lo;
        logic [23:0] form;
        c = ASCII_BASE + {1'b0, idx};
        case (c)
            8'h20: form = 24'hE38080;
            8'h22: form = 24'hE2809D;
            8'h27: form = 24'hE28099;
            8'h5C: form = 24'hEFBFA5;
            8'h60: form = 24'hE28098;
            default: begin
                if (c < 8'h60) begin
                    lo   = c + 8'h60;
                    form = {16'hEFBC, lo};
                end else begin
                    lo   = c + 8'h20;
                    form = {16'hEFBD, lo};
                end
            end
        endcase
        return form;
    endfunction

    // Character length announced by a lead byte.
    function automatic logic [2:0] lead_length(input logic [1:0] mode, input logic [7:0] b);
        logic [2:0] len;
        if (mode == MODE_UTF8) begin
            if (b[7] == 1'b0)              len = 3'd1;
            else if (b[7:5] == 3'b110)     len = 3'd2;
            else if (b[7:4] == 4'b1110)    len = 3'd3;
            else if (b[7:3] == 5'b11110)   len = 3'd4;
            else                           len = 3'd1;
        end else begin
            if (b == 8'h8F)                len = 3'd3;
            else if (b[7])                 len = 3'd2;
            else                           len = 3'd1;
        end
        return len;
    endfunction

endpackage

// ----- rtl/fwhw_match.sv -----
// Parallel compare of a completed character against the full-width form table.
module fwhw_match (
    input  logic [1:0]      i_mode,
    input  logic [1:0]      i_pend_cnt,
    input  logic [7:0]      i_p0,
    input  logic [7:0]      i_p1,
    input  logic [7:0]      i_byte,
    output fwhw_pkg::t_match o_match
);

    logic [fwhw_pkg::TABLE_ENTRIES-1:0] w_hits;
    logic                               w_utf8_chk;
    logic                               w_euc_chk;

    // UTF-8 matches only three-byte characters, EUC-JP only two-byte ones.
    assign w_utf8_chk = (i_mode == fwhw_pkg::MODE_UTF8) && (i_pend_cnt == 2'd2);
    assign w_euc_chk  = (i_mode == fwhw_pkg::MODE_EUC)  && (i_pend_cnt == 2'd1);

    always_comb begin
        for (int i = 0; i < fwhw_pkg::TABLE_ENTRIES; i++) begin
            w_hits[i] = (w_utf8_chk &&
                         ({i_p0, i_p1, i_byte} ==
                          fwhw_pkg::utf8_form(fwhw_pkg::IDX_W'(i)))) ||
                        (w_euc_chk && ({i_p0, i_byte} == fwhw_pkg::EUC_FORMS[i]));
        end
    end

    // The lowest matching entry wins.
    always_comb begin
        o_match.hit = |w_hits;
        o_match.idx = '0;
        for (int i = fwhw_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (w_hits[i]) begin
                o_match.idx = fwhw_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ----- rtl/fullwidth_to_halfwidth_folder_core.sv -----
// Top level of the full-width to half-width folder.
//
// Input channel (i_valid, o_stall, i_data) carries one string byte per item;
// in_last marks the final byte of a string. Output channel (o_valid, i_stall,
// o_data) carries result items. The mode register (i_cfg_wr_en,
// i_cfg_wr_data) selects passthrough, UTF-8 or EUC-JP; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// An accepted item is decoded in the same cycle against the pending-character
// registers and the form table; its zero to four results land in a four-entry
// result buffer and appear starting the next cycle, one per cycle unless the receiver stalls.
// A new item is accepted in the cycle the last result of the previous item is
// taken, so the results of one item are all drained before the next item is
// accepted: the drain of the result buffer sets the rate. run_last marks the
// last result of an item and string_end the final result of a string; a
// string with no data yields one bare marker. Reset clears the result buffer,
// pending character, stop flag and mode (passthrough). While the receiver
// stalls, the current result holds and o_stall stays high until its item's
// last result is taken.
module fullwidth_to_halfwidth_folder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  fwhw_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output fwhw_pkg::t_out_item  o_data
);

    // Character assembly state.
    logic [1:0] r_mode;
    logic [7:0] r_pend [3];
    logic [1:0] r_pcnt;
    logic [2:0] r_clen;
    logic       r_stopped;

    // Result buffer.
    logic [7:0] r_q [4];
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic       r_mark;
    logic       r_end;

    logic [7:0] n_pend [3];
    logic [1:0] n_pcnt;
    logic [2:0] n_clen;
    logic       n_stopped;
    logic [7:0] n_q [4];
    logic [2:0] n_cnt;
    logic       n_mark;

    logic            w_accept;
    logic            w_drain;
    logic            w_pass;
    logic            w_complete;
    logic [2:0]      w_len;
    logic [7:0]      w_list [4];
    fwhw_pkg::t_match w_match;
    logic            w_is_last;

    fwhw_match u_match (
        .i_mode     (r_mode),
        .i_pend_cnt (r_pcnt),
        .i_p0       (r_pend[0]),
        .i_p1       (r_pend[1]),
        .i_byte     (i_data.in_byte),
        .o_match    (w_match)
    );

    assign w_is_last = (r_idx == 2'(r_cnt - 3'd1));
    assign o_valid   = (r_cnt != 3'd0);
    assign w_drain   = o_valid && !i_stall && w_is_last;
    assign o_stall   = o_valid && !w_drain;
    assign w_accept  = i_valid && !o_stall;

    assign o_data.out_byte   = r_q[r_idx];
    assign o_data.out_valid  = !r_mark;
    assign o_data.run_last   = w_is_last;
    assign o_data.string_end = w_is_last && r_end;

    assign w_pass     = (r_mode != fwhw_pkg::MODE_UTF8) && (r_mode != fwhw_pkg::MODE_EUC);
    assign w_len      = fwhw_pkg::lead_length(r_mode, i_data.in_byte);
    assign w_complete = (({1'b0, r_pcnt} + 3'd1) >= r_clen) || (r_pcnt == 2'd3);

    // Pending bytes in arrival order, followed by the new byte.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (k < 3 && 2'(k) < r_pcnt) begin
                w_list[k] = r_pend[k];
            end else begin
                w_list[k] = i_data.in_byte;
            end
        end
    end

    always_comb begin
        n_pend    = r_pend;
        n_pcnt    = r_pcnt;
        n_clen    = r_clen;
        n_stopped = r_stopped;
        n_q       = w_list;
        n_cnt     = 3'd0;
        n_mark    = 1'b0;

        if (w_pass) begin
            n_cnt  = {1'b0, r_pcnt} + 3'd1;
            n_pcnt = 2'd0;
            n_clen = 3'd0;
        end else if (r_stopped) begin
            n_cnt = 3'd0;
        end else if (r_pcnt == 2'd0) begin
            if (i_data.in_byte == 8'h00) begin
                n_stopped = 1'b1;
            end else if (w_len == 3'd1) begin
                n_cnt = 3'd1;
            end else begin
                n_pend[0] = i_data.in_byte;
                n_pcnt    = 2'd1;
                n_clen    = w_len;
                // A started character at the string end is emitted as-is.
                n_cnt     = i_data.in_last ? 3'd1 : 3'd0;
            end
        end else if (w_complete) begin
            n_pcnt = 2'd0;
            n_clen = 3'd0;
            if (w_match.hit) begin
                n_q[0] = fwhw_pkg::ASCII_BASE + {1'b0, w_match.idx};
                n_cnt  = 3'd1;
            end else begin
                n_cnt  = {1'b0, r_pcnt} + 3'd1;
            end
        end else begin
            n_pend[r_pcnt] = i_data.in_byte;
            n_pcnt         = r_pcnt + 2'd1;
            n_cnt          = i_data.in_last ? ({1'b0, r_pcnt} + 3'd1) : 3'd0;
        end

        if (i_data.in_last) begin
            n_pcnt    = 2'd0;
            n_clen    = 3'd0;
            n_stopped = 1'b0;
            if (n_cnt == 3'd0) begin
                n_cnt  = 3'd1;
                n_mark = 1'b1;
                n_q[0] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= fwhw_pkg::MODE_PASS;
            r_pcnt    <= 2'd0;
            r_clen    <= 3'd0;
            r_stopped <= 1'b0;
            r_cnt     <= 3'd0;
            r_idx     <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_pcnt    <= n_pcnt;
                r_clen    <= n_clen;
                r_stopped <= n_stopped;
                r_cnt     <= n_cnt;
                r_idx     <= 2'd0;
            end else if (w_drain) begin
                r_cnt <= 3'd0;
                r_idx <= 2'd0;
            end else if (o_valid && !i_stall) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= n_pend;
            r_q    <= n_q;
            r_mark <= n_mark;
            r_end  <= i_data.in_last;
        end
    end

`ifndef ASSERT_OFF
    a_stall_needs_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with an empty result buffer");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index beyond result count");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.in_last) |=> (r_pcnt == 2'd0 && r_clen == 3'd0 && !r_stopped))
        else $error("string end did not clear the character state");

    a_marker_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.out_valid) |-> (r_cnt == 3'd1 && o_data.string_end))
        else $error("bare end marker is not the sole final result");

    a_pending_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt != 2'd0) |-> ({1'b0, r_pcnt} < r_clen))
        else $error("pending bytes reach the announced length");
`endif

endmodule
